// ----- hw/rtl/mrtu_pkg.sv -----
// Shared types, codes and the CRC-16 step for the Modbus RTU master engine.
`timescale 1ns / 1ps

package mrtu_pkg;

   typedef struct packed {
      logic [1:0]  op;
      logic [1:0]  kind;
      logic [7:0]  unit_id;
      logic [15:0] start_addr;
      logic [15:0] quantity;
      logic [15:0] data_word;
      logic [7:0]  rx_byte;
      logic        fault_kind;
   } mrtu_req_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [7:0]  tx_byte;
      logic [3:0]  reg_index;
      logic [15:0] reg_value;
      logic [3:0]  status;
      logic        last;
   } mrtu_rsp_type;

   // Item operations.
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_BYTE  = 2'd2;
   localparam logic [1:0] OP_FAULT = 2'd3;

   // Request kinds.
   localparam logic [1:0] KIND_RD_HOLD = 2'd0;
   localparam logic [1:0] KIND_RD_IN   = 2'd1;
   localparam logic [1:0] KIND_WRITE   = 2'd2;

   // Result kinds.
   localparam logic [1:0] OUT_TX   = 2'd0;
   localparam logic [1:0] OUT_WORD = 2'd1;
   localparam logic [1:0] OUT_STAT = 2'd2;

   // Transaction status codes.
   localparam logic [3:0] ST_OK      = 4'd0;
   localparam logic [3:0] ST_UART    = 4'd1;
   localparam logic [3:0] ST_TIMEOUT = 4'd2;
   localparam logic [3:0] ST_CRC     = 4'd3;
   localparam logic [3:0] ST_ID      = 4'd4;
   localparam logic [3:0] ST_EXC     = 4'd5;
   localparam logic [3:0] ST_FUNC    = 4'd6;
   localparam logic [3:0] ST_LEN     = 4'd7;
   localparam logic [3:0] ST_PARAM   = 4'd8;

   // Modbus function codes.
   localparam logic [7:0] FC_RD_HOLD = 8'h03;
   localparam logic [7:0] FC_RD_IN   = 8'h04;
   localparam logic [7:0] FC_WRITE   = 8'h10;
   localparam logic [7:0] EXC_BIT    = 8'h80;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic       cap_item;
      logic       start_req;
      logic       load_word;
      logic       rx_store;
      logic       rd_hi;
      logic       rd_lo;
      logic       word_clr;
      logic       word_next;
      logic       tx_next;
      logic       out_load;
      logic [1:0] out_sel;
      logic [3:0] stat_code;
   } mrtu_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       param_ok;
      logic       is_write;
      logic       fault_kind;
      logic       rx_done;
      logic       tx_last;
      logic       word_last;
      logic [3:0] chk_status;
   } mrtu_sts_type;

   function automatic logic [7:0] func_code(input logic [1:0] kind);
      logic [7:0] fc;
      case (kind)
         KIND_RD_HOLD: fc = FC_RD_HOLD;
         KIND_RD_IN:   fc = FC_RD_IN;
         default:      fc = FC_WRITE;
      endcase
      return fc;
   endfunction

   // One byte through the reflected CRC-16, eight shift steps.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      r = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/mrtu_datapath.sv -----
// Datapath: request registers, write buffer, receive memory, CRC and result register.
`timescale 1ns / 1ps

module mrtu_datapath #(
   parameter int MAX_REGS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mrtu_pkg::mrtu_req_type req_data,
   input  mrtu_pkg::mrtu_cmd_type cmd,
   output mrtu_pkg::mrtu_sts_type sts,
   output mrtu_pkg::mrtu_rsp_type rsp_data
);
   import mrtu_pkg::*;

   localparam int RX_DEPTH = 5 + 2 * MAX_REGS;
   localparam int RXW = $clog2(RX_DEPTH + 2);
   localparam int RXA = $clog2(RX_DEPTH);
   localparam int TXW = $clog2(9 + 2 * MAX_REGS);
   localparam int QW  = $clog2(MAX_REGS + 1);
   localparam int WIW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

   mrtu_req_type  item_ff;
   logic [1:0]    kind_ff;
   logic [7:0]    tid_ff;
   logic [15:0]   addr_ff;
   logic [QW-1:0] cnt_ff;
   logic [15:0]   words_ff [MAX_REGS];
   logic [QW-1:0] loaded_ff;
   logic [RXW-1:0] rx_cnt_ff;
   logic [15:0]   rx_crc_ff;
   logic [7:0]    rx_mem [RX_DEPTH];
   logic [7:0]    rd_data_ff;
   logic [7:0]    hi_ff;
   logic [7:0]    b0_ff, b1_ff, b2_ff, b3_ff, b4_ff, b5_ff;
   logic [7:0]    prev1_ff, prev2_ff;
   logic [TXW-1:0] tx_cnt_ff;
   logic [15:0]   tx_crc_ff;
   logic [QW-1:0] wi_ff;
   mrtu_rsp_type  rsp_ff;

   logic           is_write;
   logic [RXW-1:0] exp_len;
   logic [TXW-1:0] body_len;
   logic [TXW-1:0] wsel;
   logic [WIW-1:0] widx;
   logic [15:0]    tx_word;
   logic [7:0]     tx_byte;
   logic [RXW-1:0] rd_addr;
   logic [3:0]     chk;
   mrtu_rsp_type   rsp_in;

   assign is_write = (kind_ff == KIND_WRITE);
   assign exp_len  = is_write ? RXW'(8) : RXW'(5 + 2 * int'(cnt_ff));
   assign body_len = is_write ? TXW'(7 + 2 * int'(cnt_ff)) : TXW'(6);
   assign wsel     = tx_cnt_ff - TXW'(7);
   assign widx     = WIW'(wsel >> 1);
   assign tx_word  = words_ff[widx];

   always_comb begin
      case (tx_cnt_ff)
         TXW'(0): tx_byte = tid_ff;
         TXW'(1): tx_byte = func_code(kind_ff);
         TXW'(2): tx_byte = addr_ff[15:8];
         TXW'(3): tx_byte = addr_ff[7:0];
         TXW'(4): tx_byte = 8'h00;
         TXW'(5): tx_byte = 8'(cnt_ff);
         TXW'(6): tx_byte = is_write ? 8'(2 * int'(cnt_ff)) : tx_crc_ff[7:0];
         default: begin
            if (tx_cnt_ff < body_len) begin
               tx_byte = wsel[0] ? tx_word[7:0] : tx_word[15:8];
            end else if (tx_cnt_ff == body_len) begin
               tx_byte = tx_crc_ff[7:0];
            end else begin
               tx_byte = tx_crc_ff[15:8];
            end
         end
      endcase
   end

   // Response checks, in priority order.
   always_comb begin
      if ({prev1_ff, prev2_ff} != rx_crc_ff) begin
         chk = ST_CRC;
      end else if (b0_ff != tid_ff) begin
         chk = ST_ID;
      end else if ((b1_ff & EXC_BIT) != 8'h00) begin
         chk = ST_EXC;
      end else if (b1_ff != func_code(kind_ff)) begin
         chk = ST_FUNC;
      end else if (is_write) begin
         chk = ({b2_ff, b3_ff} != addr_ff || {b4_ff, b5_ff} != 16'(cnt_ff)) ? ST_LEN : ST_OK;
      end else begin
         chk = (b2_ff != 8'(2 * int'(cnt_ff))) ? ST_LEN : ST_OK;
      end
   end

   assign sts.op         = item_ff.op;
   assign sts.param_ok   = (item_ff.kind <= KIND_WRITE) && (item_ff.quantity != 16'd0)
                           && (item_ff.quantity <= 16'(MAX_REGS));
   assign sts.is_write   = is_write;
   assign sts.fault_kind = item_ff.fault_kind;
   assign sts.rx_done    = ((rx_cnt_ff + RXW'(1)) >= exp_len);
   assign sts.tx_last    = (tx_cnt_ff == body_len + TXW'(1));
   assign sts.word_last  = (wi_ff == cnt_ff - QW'(1));
   assign sts.chk_status = chk;

   assign rd_addr = RXW'(3 + 2 * int'(wi_ff)) + (cmd.rd_lo ? RXW'(1) : RXW'(0));

   always_comb begin
      rsp_in = '0;
      rsp_in.out_kind = cmd.out_sel;
      case (cmd.out_sel)
         OUT_TX: begin
            rsp_in.tx_byte = tx_byte;
            rsp_in.last    = sts.tx_last;
         end
         OUT_WORD: begin
            rsp_in.reg_index = 4'(wi_ff);
            rsp_in.reg_value = {hi_ff, rd_data_ff};
         end
         default: begin
            rsp_in.status = cmd.stat_code;
            rsp_in.last   = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= '0;
         tid_ff    <= '0;
         addr_ff   <= '0;
         cnt_ff    <= '0;
         loaded_ff <= '0;
         rx_cnt_ff <= '0;
         rx_crc_ff <= CRC_INIT;
         for (int i = 0; i < MAX_REGS; i++) begin
            words_ff[i] <= '0;
         end
      end else begin
         if (cmd.start_req) begin
            kind_ff   <= item_ff.kind;
            tid_ff    <= item_ff.unit_id;
            addr_ff   <= item_ff.start_addr;
            cnt_ff    <= QW'(item_ff.quantity);
            rx_cnt_ff <= '0;
            rx_crc_ff <= CRC_INIT;
            if (item_ff.kind == KIND_WRITE) begin
               loaded_ff <= '0;
            end
         end
         if (cmd.load_word && loaded_ff < QW'(MAX_REGS)) begin
            words_ff[WIW'(loaded_ff)] <= item_ff.data_word;
            loaded_ff <= loaded_ff + QW'(1);
         end
         if (cmd.rx_store) begin
            // The last two bytes carry the CRC and stay out of the running sum.
            if (rx_cnt_ff + RXW'(2) < exp_len) begin
               rx_crc_ff <= crc_byte(rx_crc_ff, item_ff.rx_byte);
            end
            rx_cnt_ff <= rx_cnt_ff + RXW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_item) begin
         item_ff <= req_data;
      end
      if (cmd.rx_store) begin
         rx_mem[RXA'(rx_cnt_ff)] <= item_ff.rx_byte;
         prev1_ff <= item_ff.rx_byte;
         prev2_ff <= prev1_ff;
         if (rx_cnt_ff == RXW'(0)) b0_ff <= item_ff.rx_byte;
         if (rx_cnt_ff == RXW'(1)) b1_ff <= item_ff.rx_byte;
         if (rx_cnt_ff == RXW'(2)) b2_ff <= item_ff.rx_byte;
         if (rx_cnt_ff == RXW'(3)) b3_ff <= item_ff.rx_byte;
         if (rx_cnt_ff == RXW'(4)) b4_ff <= item_ff.rx_byte;
         if (rx_cnt_ff == RXW'(5)) b5_ff <= item_ff.rx_byte;
      end
      if (cmd.rd_hi || cmd.rd_lo) begin
         rd_data_ff <= rx_mem[RXA'(rd_addr)];
      end
      if (cmd.rd_lo) begin
         hi_ff <= rd_data_ff;
      end
      if (cmd.start_req) begin
         tx_cnt_ff <= '0;
         tx_crc_ff <= CRC_INIT;
      end else if (cmd.tx_next) begin
         if (tx_cnt_ff < body_len) begin
            tx_crc_ff <= crc_byte(tx_crc_ff, tx_byte);
         end
         tx_cnt_ff <= tx_cnt_ff + TXW'(1);
      end
      if (cmd.word_clr) begin
         wi_ff <= '0;
      end else if (cmd.word_next) begin
         wi_ff <= wi_ff + QW'(1);
      end
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- hw/rtl/mrtu_controller.sv -----
// Controller: transaction sequencing and result handshake.
`timescale 1ns / 1ps

module mrtu_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  mrtu_pkg::mrtu_sts_type sts,
   output mrtu_pkg::mrtu_cmd_type cmd
);
   import mrtu_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_TX    = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_RDH   = 3'd4;
   localparam logic [2:0] S_RDL   = 3'd5;
   localparam logic [2:0] S_WORD  = 3'd6;
   localparam logic [2:0] S_STAT  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       phase_ff, phase_in;
   logic [3:0] stat_ff, stat_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free  = !valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      stat_in  = stat_ff;
      cmd      = '0;
      cmd.stat_code = stat_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.cap_item = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (sts.op)
               OP_START: begin
                  if (sts.param_ok) begin
                     cmd.start_req = 1'b1;
                     phase_in = 1'b1;
                     state_in = S_TX;
                  end else begin
                     stat_in  = ST_PARAM;
                     state_in = S_STAT;
                  end
               end
               OP_LOAD: begin
                  cmd.load_word = 1'b1;
                  state_in = S_IDLE;
               end
               OP_BYTE: begin
                  state_in = S_IDLE;
                  if (phase_ff) begin
                     cmd.rx_store = 1'b1;
                     if (sts.rx_done) begin
                        phase_in = 1'b0;
                        state_in = S_CHECK;
                     end
                  end
               end
               default: begin
                  state_in = S_IDLE;
                  if (phase_ff) begin
                     stat_in  = sts.fault_kind ? ST_TIMEOUT : ST_UART;
                     phase_in = 1'b0;
                     state_in = S_STAT;
                  end
               end
            endcase
         end
         S_TX: begin
            cmd.out_sel = OUT_TX;
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.tx_next  = 1'b1;
               if (sts.tx_last) state_in = S_IDLE;
            end
         end
         S_CHECK: begin
            if (sts.chk_status == ST_OK && !sts.is_write) begin
               cmd.word_clr = 1'b1;
               state_in = S_RDH;
            end else begin
               stat_in  = sts.chk_status;
               state_in = S_STAT;
            end
         end
         S_RDH: begin
            cmd.rd_hi = 1'b1;
            state_in = S_RDL;
         end
         S_RDL: begin
            cmd.rd_lo = 1'b1;
            state_in = S_WORD;
         end
         S_WORD: begin
            cmd.out_sel = OUT_WORD;
            if (out_free) begin
               cmd.out_load  = 1'b1;
               cmd.word_next = 1'b1;
               if (sts.word_last) begin
                  stat_in  = ST_OK;
                  state_in = S_STAT;
               end else begin
                  state_in = S_RDH;
               end
            end
         end
         default: begin
            cmd.out_sel = OUT_STAT;
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
      valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 1'b0;
         stat_ff  <= ST_OK;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         stat_ff  <= stat_in;
         valid_ff <= valid_in;
      end
   end

   // A pending result is never overwritten before it is taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result register overwritten");

   // The response check always runs with the transaction already closed.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> !phase_ff)
      else $error("check with transaction still open");

   // Register words are only sent after a completed response.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WORD) |-> (!phase_ff && !sts.is_write))
      else $error("word emitted outside a read response");

   // Frame bytes only go out while a transaction is open.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TX) |-> phase_ff)
      else $error("frame byte without open transaction");

endmodule

// ----- hw/rtl/modbus_rtu_master_engine.sv -----
// Top level of the Modbus RTU master engine.
`timescale 1ns / 1ps

// Modbus RTU master. Each input item is handled one at a time: an item is
// captured in the idle state and run in the execute state; then a start
// request streams its frame bytes one per cycle while the output is free
// (8 bytes for a read, 9 + 2q for a write), and a completed response streams
// its register words, each read high then low byte via the single read port
// of the receive byte memory. A received byte that does not complete a
// response returns to idle from the execute state. Results leave through an
// output register, so the next item is taken while the final result of the
// previous one still waits. Up to MAX_REGS (1 to 16) registers per request;
// the write buffer resets to zero, the receive buffer needs no clearing.

module modbus_rtu_master_engine #(
   parameter int MAX_REGS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mrtu_pkg::mrtu_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mrtu_pkg::mrtu_rsp_type rsp_data
);
   import mrtu_pkg::*;

   mrtu_cmd_type cmd;
   mrtu_sts_type sts;

   mrtu_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mrtu_datapath #(
      .MAX_REGS (MAX_REGS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

// ----- verif/modbus_rtu_master_engine_tb.sv -----
// Self-checking testbench for the Modbus RTU master engine.
`timescale 1ns / 1ps

module modbus_rtu_master_engine_tb;
   import mrtu_pkg::*;

   localparam int NREGS = 16;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   mrtu_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   mrtu_rsp_type rsp_data;

   modbus_rtu_master_engine #(.MAX_REGS(NREGS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // Predictor state of the engine.
   logic        waiting;
   logic [1:0]  cur_kind;
   logic [7:0]  cur_id;
   logic [15:0] cur_addr;
   logic [4:0]  cur_count;
   logic [15:0] wr_buf [NREGS];
   logic [4:0]  wr_fill;
   logic [5:0]  rx_fill;
   logic [7:0]  rx_buf [5 + 2 * NREGS];
   logic [15:0] rx_crc;

   mrtu_req_type pending_items[$];
   mrtu_rsp_type expected_rsps[$];
   int  errors = 0;
   int  rsp_seen = 0;
   int  items_sent = 0;
   bit  hold_off = 0;
   int  in_gap = 0;
   int  out_gap = 0;

   // Transmit history for building well-formed responses.
   logic [1:0]  last_kind;
   logic [7:0]  last_id;
   logic [15:0] last_addr;
   logic [15:0] last_q;

   function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      c = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
   endfunction

   function automatic logic [7:0] fcode(logic [1:0] k);
      return (k == KIND_RD_HOLD) ? FC_RD_HOLD : (k == KIND_RD_IN) ? FC_RD_IN : FC_WRITE;
   endfunction

   function automatic int resp_len();
      return (cur_kind == KIND_WRITE) ? 8 : 5 + 2 * cur_count;
   endfunction

   task automatic push_rsp(logic [1:0] k, logic [7:0] b, logic [3:0] idx,
                           logic [15:0] v, logic [3:0] st);
      mrtu_rsp_type r;
      r = '{out_kind: k, tx_byte: b, reg_index: idx, reg_value: v, status: st, last: 1'b0};
      expected_rsps.push_back(r);
   endtask

   task automatic predict_item(mrtu_req_type it);
      int n0;
      int len;
      logic [7:0]  fr [64];
      logic [15:0] c;
      logic [15:0] got;
      logic [3:0]  st;
      n0 = expected_rsps.size();
      case (it.op)
         OP_START: begin
            if (it.kind > KIND_WRITE || it.quantity == 0 || it.quantity > NREGS) begin
               push_rsp(OUT_STAT, 0, 0, 0, ST_PARAM);
            end else begin
               cur_kind = it.kind; cur_id = it.unit_id;
               cur_addr = it.start_addr; cur_count = it.quantity[4:0];
               len = 0;
               fr[len++] = it.unit_id; fr[len++] = fcode(it.kind);
               fr[len++] = it.start_addr[15:8]; fr[len++] = it.start_addr[7:0];
               fr[len++] = it.quantity[15:8]; fr[len++] = it.quantity[7:0];
               if (it.kind == KIND_WRITE) begin
                  fr[len++] = 8'(it.quantity * 2);
                  for (int i = 0; i < it.quantity; i++) begin
                     fr[len++] = wr_buf[i][15:8]; fr[len++] = wr_buf[i][7:0];
                  end
                  wr_fill = 0;
               end
               c = 16'hFFFF;
               for (int i = 0; i < len; i++) c = crc_step(c, fr[i]);
               fr[len++] = c[7:0]; fr[len++] = c[15:8];
               for (int i = 0; i < len; i++) push_rsp(OUT_TX, fr[i], 0, 0, 0);
               waiting = 1; rx_fill = 0; rx_crc = 16'hFFFF;
            end
         end
         OP_LOAD: begin
            if (wr_fill < NREGS) begin
               wr_buf[wr_fill] = it.data_word;
               wr_fill++;
            end
         end
         OP_BYTE: begin
            if (waiting) begin
               len = resp_len();
               if (rx_fill < len) begin
                  rx_buf[rx_fill] = it.rx_byte;
                  if (rx_fill + 2 < len) rx_crc = crc_step(rx_crc, it.rx_byte);
                  rx_fill++;
               end
               if (rx_fill >= len) begin
                  got = {rx_buf[len - 1], rx_buf[len - 2]};
                  st = ST_OK;
                  if (got != rx_crc) st = ST_CRC;
                  else if (rx_buf[0] != cur_id) st = ST_ID;
                  else if (rx_buf[1][7]) st = ST_EXC;
                  else if (rx_buf[1] != fcode(cur_kind)) st = ST_FUNC;
                  else if (cur_kind == KIND_WRITE) begin
                     if ({rx_buf[2], rx_buf[3]} != cur_addr ||
                         {rx_buf[4], rx_buf[5]} != {11'd0, cur_count}) st = ST_LEN;
                  end else if (rx_buf[2] != 8'(cur_count * 2)) st = ST_LEN;
                  if (st == ST_OK && cur_kind != KIND_WRITE)
                     for (int i = 0; i < cur_count; i++)
                        push_rsp(OUT_WORD, 0, 4'(i), {rx_buf[3 + 2 * i], rx_buf[4 + 2 * i]}, 0);
                  push_rsp(OUT_STAT, 0, 0, 0, st);
                  waiting = 0;
               end
            end
         end
         default: begin
            if (waiting) begin
               push_rsp(OUT_STAT, 0, 0, 0, it.fault_kind ? ST_TIMEOUT : ST_UART);
               waiting = 0;
            end
         end
      endcase
      if (expected_rsps.size() > n0) expected_rsps[$].last = 1'b1;
   endtask

   function automatic mrtu_req_type noise_item();
      mrtu_req_type it;
      it = mrtu_req_type'($bits(mrtu_req_type)'({$urandom, $urandom, $urandom}));
      return it;
   endfunction

   task automatic add_start(logic [1:0] k, logic [7:0] id, logic [15:0] a, logic [15:0] q);
      mrtu_req_type it;
      it = noise_item();
      it.op = OP_START; it.kind = k; it.unit_id = id; it.start_addr = a; it.quantity = q;
      pending_items.push_back(it);
      last_kind = k; last_id = id; last_addr = a; last_q = q;
   endtask

   task automatic add_byte(logic [7:0] b);
      mrtu_req_type it;
      it = noise_item();
      it.op = OP_BYTE; it.rx_byte = b;
      pending_items.push_back(it);
   endtask

   task automatic add_load(logic [15:0] w);
      mrtu_req_type it;
      it = noise_item();
      it.op = OP_LOAD; it.data_word = w;
      pending_items.push_back(it);
   endtask

   task automatic add_fault(logic fk);
      mrtu_req_type it;
      it = noise_item();
      it.op = OP_FAULT; it.fault_kind = fk;
      pending_items.push_back(it);
   endtask

   // Sends a response to the last start; flaw picks a corruption, 0 for none.
   task automatic add_reply(int flaw, bit full_range);
      logic [7:0]  rb [64];
      int          len;
      logic [15:0] c;
      len = 0;
      rb[len++] = last_id;
      rb[len++] = fcode(last_kind);
      if (last_kind == KIND_WRITE) begin
         rb[len++] = last_addr[15:8]; rb[len++] = last_addr[7:0];
         rb[len++] = last_q[15:8];    rb[len++] = last_q[7:0];
      end else begin
         rb[len++] = 8'(last_q * 2);
         for (int i = 0; i < last_q; i++) begin
            rb[len++] = full_range ? 8'hFF : 8'($urandom);
            rb[len++] = full_range ? 8'h00 : 8'($urandom);
         end
      end
      case (flaw)
         1: rb[0] = rb[0] ^ 8'(1 << $urandom_range(0, 7));
         2: rb[1] = rb[1] | EXC_BIT;
         3: rb[1] = (last_kind == KIND_WRITE) ? FC_RD_HOLD : FC_WRITE;
         4: rb[2] = rb[2] ^ 8'(1 << $urandom_range(0, 7));
         5: rb[$urandom_range(4, 5)] ^= 8'(1 << $urandom_range(0, 7));
         default: ;
      endcase
      c = 16'hFFFF;
      for (int i = 0; i < len; i++) c = crc_step(c, rb[i]);
      rb[len++] = c[7:0]; rb[len++] = c[15:8];
      if (flaw == 6) rb[len - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
      for (int i = 0; i < len; i++) add_byte(rb[i]);
   endtask

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("** modbus_rtu_master_engine: FAILED **");
      $finish;
   end

   // Driver: the predictor runs on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         in_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_item(req_data);
            items_sent++;
         end
         if (req_valid && !req_ready) begin
         end else if (in_gap > 0) begin
            in_gap <= in_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0 && !hold_off) begin
            req_data <= pending_items.pop_front();
            req_valid <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               in_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor with random back-pressure.
   always @(posedge clock) begin
      mrtu_rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
         out_gap <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_data.out_kind !== e.out_kind || rsp_data.tx_byte !== e.tx_byte ||
                   rsp_data.reg_index !== e.reg_index || rsp_data.reg_value !== e.reg_value ||
                   rsp_data.status !== e.status || rsp_data.last !== e.last) begin
                  $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
                  errors++;
               end
            end
         end
         if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 4) == 0)
               out_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
         end
      end
   end

   // Sampled at the falling edge so that the driver's updates have settled.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_items.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(negedge clock);
      repeat (100) @(posedge clock);
   endtask

   initial begin
      int sel;
      logic [1:0] k;
      int q;
      waiting = 0; cur_kind = 0; cur_id = 0; cur_addr = 0; cur_count = 0;
      wr_fill = 0; rx_fill = 0; rx_crc = 16'hFFFF;
      for (int i = 0; i < NREGS; i++) wr_buf[i] = 0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part: idle byte and fault, bad requests, writes from reset values.
      add_byte(8'hA5);
      add_fault(1'b0);
      add_start(2'd3, 8'h01, 16'h0000, 16'd1);
      add_start(KIND_RD_HOLD, 8'h01, 16'h0000, 16'd0);
      add_start(KIND_RD_IN, 8'h01, 16'h0000, 16'(NREGS + 1));
      add_start(KIND_WRITE, 8'hFF, 16'hFFFF, 16'(NREGS));
      add_reply(0, 0);
      add_start(KIND_RD_HOLD, 8'h00, 16'h0000, 16'd1);
      add_reply(0, 1);
      add_start(KIND_RD_IN, 8'hFF, 16'hFFFF, 16'(NREGS));
      add_reply(0, 1);
      add_start(KIND_RD_HOLD, 8'h11, 16'h1234, 16'd2);
      add_fault(1'b1);
      add_start(KIND_RD_HOLD, 8'h11, 16'h1234, 16'd2);
      add_start(KIND_RD_IN, 8'h12, 16'h0010, 16'd1);
      add_fault(1'b0);
      wait_drained();

      // Pause until all results are in before the random part.
      hold_off = 1;
      repeat (20) @(posedge clock);
      hold_off = 0;

      while (pending_items.size() + items_sent < 370) begin
         sel = $urandom_range(0, 9);
         if (sel < 7) begin
            k = 2'($urandom_range(0, 2));
            q = ($urandom_range(0, 7) == 0) ? NREGS : $urandom_range(1, 4);
            if (k == KIND_WRITE)
               repeat ($urandom_range(0, NREGS + 2)) add_load(16'($urandom));
            add_start(k, 8'($urandom), 16'($urandom), 16'(q));
            if ($urandom_range(0, 9) == 0) add_fault($urandom_range(0, 1));
            else add_reply(($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0, 0);
         end else if (sel == 7) begin
            add_start(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
                      ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'd0);
         end else if (sel == 8) begin
            add_fault($urandom_range(0, 1));
         end else begin
            pending_items.push_back(noise_item());
         end
         if (pending_items.size() > 50)
            while (pending_items.size() > 10) @(posedge clock);
      end
      wait_drained();

      if (expected_rsps.size() != 0) begin
         $display("%0t: expected %0d more results, actual none", $time,
                  expected_rsps.size());
         errors++;
      end

      $display("Sent %0d items and checked %0d results: frames, read and write", items_sent,
               rsp_seen);
      $display("replies with every error case, faults, bad requests and idle noise.");
      if (errors == 0) begin
         $display("** modbus_rtu_master_engine: PASSED **");
      end else begin
         $display("** modbus_rtu_master_engine: FAILED **");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/mrtu_pkg.sv
hw/rtl/mrtu_datapath.sv
hw/rtl/mrtu_controller.sv
hw/rtl/modbus_rtu_master_engine.sv
verif/modbus_rtu_master_engine_tb.sv
